>>> hdl/knn_majority_vote_classifier_unit_assert.svh
// ---------------------------------------------------------------------------
// knn assertion macros
// Shorthand for clocked assertions; expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef KNN_MAJORITY_VOTE_CLASSIFIER_UNIT_ASSERT_SVH
`define KNN_MAJORITY_VOTE_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KNN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KNN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/knn_pkg.sv
// ---------------------------------------------------------------------------
// knn_pkg
// Shared types, codes and default sizes of the k-NN classifier.
// ---------------------------------------------------------------------------
package knn_pkg;

  localparam int MAX_TRAIN_DEF   = 1024;
  localparam int MAX_DIMS_DEF    = 64;
  localparam int MAX_K_DEF       = 8;
  localparam int NUM_CLASSES_DEF = 16;

  localparam logic [10:0] TRAIN_ROWS_RST = 11'd1;
  localparam logic [6:0]  DIMS_USED_RST  = 7'd64;
  localparam logic [3:0]  NEIGHBOURS_RST = 4'd5;

  localparam logic [1:0] ACT_FEATURE = 2'd0;
  localparam logic [1:0] ACT_LABEL   = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  localparam logic [1:0] CFG_TRAIN_ROWS = 2'd0;
  localparam logic [1:0] CFG_DIMS_USED  = 2'd1;
  localparam logic [1:0] CFG_NEIGHBOURS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_VOTE,
    ST_TALLY,
    ST_OUT
  } knn_state_t;

  // Tag that travels with each element through the distance pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic lastd;
  } knn_tag_t;

endpackage

>>> hdl/knn_majority_vote_classifier_unit.sv
// ---------------------------------------------------------------------------
// knn_majority_vote_classifier_unit
// Brute-force k-nearest-neighbor classifier with majority vote.
// ---------------------------------------------------------------------------
// Load training elements (action 0) and labels (action 1) one item each.
// Query elements (action 2) are stored one per item; the item with last set
// starts a scan that streams one feature element per cycle out of the
// feature RAM. The scan pace is set by the single read port of the feature
// memory. Equal distances keep the lower row; ties in the vote keep the label
// that reached the count first. No input item is taken during the scan; a
// finished result may wait in the output register while new items arrive.
// Configuration writes are taken at any time and apply to the next query.
module knn_majority_vote_classifier_unit #(
  parameter int MAX_TRAIN   = knn_pkg::MAX_TRAIN_DEF,
  parameter int MAX_DIMS    = knn_pkg::MAX_DIMS_DEF,
  parameter int MAX_K       = knn_pkg::MAX_K_DEF,
  parameter int NUM_CLASSES = knn_pkg::NUM_CLASSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [9:0]         in_row,
  input  logic [5:0]         in_column,
  input  logic signed [15:0] in_feature_value,
  input  logic [3:0]         in_class_label,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_predicted_class,
  output logic [3:0]         out_winning_votes,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);
  import knn_pkg::*;

  localparam int RW     = $clog2(MAX_TRAIN);
  localparam int DMW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DW     = 32 + $clog2(MAX_DIMS + 1);
  localparam int KCW    = $clog2(MAX_K + 1);
  localparam int KIW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CLW    = $clog2(NUM_CLASSES);
  localparam int FDEPTH = MAX_TRAIN * (2 ** DMW);

  // configuration registers
  logic [10:0] train_rows_r;
  logic [6:0]  dims_used_r;
  logic [3:0]  neighbours_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      train_rows_r <= TRAIN_ROWS_RST;
      dims_used_r  <= DIMS_USED_RST;
      neighbours_r <= NEIGHBOURS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRAIN_ROWS: train_rows_r <= cfg_data;
        CFG_DIMS_USED:  dims_used_r  <= cfg_data[6:0];
        CFG_NEIGHBOURS: neighbours_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // saturate registers into their legal ranges
  logic [31:0] rows_c, dims_c, k_c, voters_c;
  always_comb begin
    rows_c = (train_rows_r == '0) ? 32'd1 :
             ((32'(train_rows_r) > 32'(MAX_TRAIN)) ? 32'(MAX_TRAIN) : 32'(train_rows_r));
    dims_c = (dims_used_r == '0) ? 32'd1 :
             ((32'(dims_used_r) > 32'(MAX_DIMS)) ? 32'(MAX_DIMS) : 32'(dims_used_r));
    k_c    = (neighbours_r == '0) ? 32'd1 :
             ((32'(neighbours_r) > 32'(MAX_K)) ? 32'(MAX_K) : 32'(neighbours_r));
    voters_c = (k_c < rows_c) ? k_c : rows_c;
  end

  knn_state_t state_r, state_nxt;

  logic [RW-1:0]  rows_m1_r, r_cnt_r;
  logic [DMW-1:0] dims_m1_r, d_cnt_r;
  logic [KCW-1:0] voters_r;
  logic [KIW-1:0] vi_r;
  logic           dist_busy;

  logic in_acc, start, scan_issue, scan_end, vote_clear, vote_issue, vote_end;
  logic out_load, out_valid_r;

  assign in_acc   = in_valid && in_ready;
  assign scan_end = (r_cnt_r == rows_m1_r) && (d_cnt_r == dims_m1_r);
  assign vote_end = (vi_r == KIW'(voters_r - KCW'(1)));
  assign start    = in_acc && (in_action == ACT_QUERY) && in_last;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!dist_busy) state_nxt = ST_VOTE;
      ST_VOTE:  if (vote_end) state_nxt = ST_TALLY;
      ST_TALLY: state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    scan_issue = 1'b0;
    vote_clear = 1'b0;
    vote_issue = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN:  scan_issue = 1'b1;
      ST_DRAIN: vote_clear = !dist_busy;
      ST_VOTE:  vote_issue = 1'b1;
      ST_TALLY: ;
      ST_OUT:   out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // latch the query geometry and walk rows by dimensions
  always_ff @(posedge clk) begin
    if (start) begin
      rows_m1_r <= RW'(rows_c - 32'd1);
      dims_m1_r <= DMW'(dims_c - 32'd1);
      voters_r  <= KCW'(voters_c);
      r_cnt_r   <= '0;
      d_cnt_r   <= '0;
    end else if (scan_issue) begin
      if (d_cnt_r == dims_m1_r) begin
        d_cnt_r <= '0;
        r_cnt_r <= r_cnt_r + RW'(1);
      end else begin
        d_cnt_r <= d_cnt_r + DMW'(1);
      end
    end
  end

  // training features, row-major with a power-of-two row stride
  logic               feat_we, lab_we, qry_we;
  logic signed [15:0] feat_rd, qry_rd;
  logic               row_ok, col_ok;
  logic [CLW-1:0]     lab_wdata, lab_rd;
  logic [RW-1:0]      vote_row;

  assign row_ok  = 32'(in_row) < 32'(MAX_TRAIN);
  assign col_ok  = 32'(in_column) < 32'(MAX_DIMS);
  assign feat_we = in_acc && (in_action == ACT_FEATURE) && row_ok && col_ok;
  assign lab_we  = in_acc && (in_action == ACT_LABEL) && row_ok;
  assign qry_we  = in_acc && (in_action == ACT_QUERY) && col_ok;

  // clamp labels beyond the class count to the top class
  assign lab_wdata = (32'(in_class_label) >= 32'(NUM_CLASSES)) ?
                     CLW'(NUM_CLASSES - 1) : CLW'(in_class_label);

  knn_ram #(.W(16), .DEPTH(FDEPTH), .AW(RW + DMW)) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr ({RW'(in_row), DMW'(in_column)}),
    .wdata (in_feature_value),
    .raddr ({r_cnt_r, d_cnt_r}),
    .rdata (feat_rd)
  );

  knn_ram #(.W(16), .DEPTH(MAX_DIMS), .AW(DMW)) u_qry_ram (
    .clk   (clk),
    .we    (qry_we),
    .waddr (DMW'(in_column)),
    .wdata (in_feature_value),
    .raddr (d_cnt_r),
    .rdata (qry_rd)
  );

  knn_ram #(.W(CLW), .DEPTH(MAX_TRAIN), .AW(RW)) u_lab_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (RW'(in_row)),
    .wdata (lab_wdata),
    .raddr (vote_row),
    .rdata (lab_rd)
  );

  // distance pipeline and nearest-k list
  knn_tag_t      tag;
  logic          dist_vld;
  logic [DW-1:0] dist_sum;
  logic [RW-1:0] dist_row;

  assign tag.vld   = scan_issue;
  assign tag.first = (d_cnt_r == '0);
  assign tag.lastd = (d_cnt_r == dims_m1_r);

  knn_dist #(.RW(RW), .DW(DW)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (tag),
    .row_i     (r_cnt_r),
    .train_val (feat_rd),
    .query_val (qry_rd),
    .busy      (dist_busy),
    .dist_vld  (dist_vld),
    .dist_sum  (dist_sum),
    .dist_row  (dist_row)
  );

  knn_topk #(.MAX_K(MAX_K), .RW(RW), .DW(DW), .KCW(KCW), .KIW(KIW)) u_topk (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (start),
    .upd      (dist_vld),
    .new_dist (dist_sum),
    .row      (dist_row),
    .voters   (voters_r),
    .rd_idx   (vi_r),
    .rd_row   (vote_row)
  );

  // vote: read one neighbor label per cycle, nearest first, tally next cycle
  logic [KCW-1:0] cnt_r [NUM_CLASSES];
  logic [KCW-1:0] lead_cnt_r, cnt_inc;
  logic [CLW-1:0] lead_cls_r;
  logic           vote_pend_r;

  assign cnt_inc = cnt_r[lab_rd] + KCW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vote_pend_r <= 1'b0;
    end else begin
      vote_pend_r <= vote_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (vote_clear) begin
      vi_r <= '0;
    end else if (vote_issue) begin
      vi_r <= vi_r + KIW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || vote_clear) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_r[c] <= '0;
      end
      lead_cnt_r <= '0;
      lead_cls_r <= '0;
    end else if (vote_pend_r) begin
      cnt_r[lab_rd] <= cnt_inc;
      // take the lead only on a strictly greater count
      if (cnt_inc > lead_cnt_r) begin
        lead_cnt_r <= cnt_inc;
        lead_cls_r <= lab_rd;
      end
    end
  end

  // output register; holds until taken
  logic [3:0] out_cls_r, out_votes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cls_r   <= 4'(lead_cls_r);
      out_votes_r <= 4'(lead_cnt_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_cls_r;
  assign out_winning_votes   = out_votes_r;

`include "knn_majority_vote_classifier_unit_assert.svh"

  `KNN_ASSERT_IMP(a_idle_pipe_empty, in_ready, !dist_busy, "distance pipeline busy while idle")
  `KNN_ASSERT_NXT(a_scan_flow, state_r == ST_SCAN, state_r == ST_SCAN || state_r == ST_DRAIN, "scan left early")
  `KNN_ASSERT_IMP(a_vote_nonzero, state_r == ST_OUT, lead_cnt_r != '0, "vote produced no winner")
  `KNN_ASSERT_IMP(a_no_tally_idle, vote_pend_r, state_r == ST_VOTE || state_r == ST_TALLY, "tally outside vote")

endmodule

>>> hdl/knn_ram.sv
// ---------------------------------------------------------------------------
// knn_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module knn_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/knn_dist.sv
// ---------------------------------------------------------------------------
// knn_dist
// Squared L2 distance pipeline: difference, square, accumulate per row.
// ---------------------------------------------------------------------------
module knn_dist #(
  parameter int RW = 10,
  parameter int DW = 39
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  knn_pkg::knn_tag_t       tag_i,
  input  logic [RW-1:0]           row_i,
  input  logic signed [15:0]      train_val,
  input  logic signed [15:0]      query_val,
  output logic                    busy,
  output logic                    dist_vld,
  output logic [DW-1:0]           dist_sum,
  output logic [RW-1:0]           dist_row
);
  import knn_pkg::*;

  knn_tag_t      tag0_r, tag1_r, tag2_r;
  logic [RW-1:0] row0_r, row1_r, row2_r, dist_row_r;
  logic [15:0]   mag_r;
  logic [31:0]   sq_r;
  logic [DW-1:0] acc_r;
  logic          dist_vld_r;
  logic signed [16:0] diff;
  logic [16:0]   mag_full;

  // RAM data lines up with stage 0
  assign diff     = 17'(train_val) - 17'(query_val);
  assign mag_full = diff[16] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r     <= '0;
      tag1_r     <= '0;
      tag2_r     <= '0;
      dist_vld_r <= 1'b0;
    end else begin
      tag0_r     <= tag_i;
      tag1_r     <= tag0_r;
      tag2_r     <= tag1_r;
      dist_vld_r <= tag2_r.vld && tag2_r.lastd;
    end
  end

  always_ff @(posedge clk) begin
    row0_r <= row_i;
    row1_r <= row0_r;
    row2_r <= row1_r;
    mag_r  <= mag_full[15:0];
    sq_r   <= 32'(mag_r) * 32'(mag_r);
    if (tag2_r.vld) begin
      acc_r      <= (tag2_r.first ? '0 : acc_r) + DW'(sq_r);
      dist_row_r <= row2_r;
    end
  end

  assign busy     = tag0_r.vld || tag1_r.vld || tag2_r.vld || dist_vld_r;
  assign dist_vld = dist_vld_r;
  assign dist_sum = acc_r;
  assign dist_row = dist_row_r;

endmodule

>>> hdl/knn_topk.sv
// ---------------------------------------------------------------------------
// knn_topk
// Sorted list of the k nearest rows, one insertion per cycle.
// ---------------------------------------------------------------------------
module knn_topk #(
  parameter int MAX_K = 8,
  parameter int RW    = 10,
  parameter int DW    = 39,
  parameter int KCW   = 4,
  parameter int KIW   = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clear,
  input  logic           upd,
  input  logic [DW-1:0]  new_dist,
  input  logic [RW-1:0]  row,
  input  logic [KCW-1:0] voters,
  input  logic [KIW-1:0] rd_idx,
  output logic [RW-1:0]  rd_row
);

  logic [DW-1:0] best_d_r   [MAX_K];
  logic [RW-1:0] best_row_r [MAX_K];
  logic [DW-1:0] best_d_nxt   [MAX_K];
  logic [RW-1:0] best_row_nxt [MAX_K];
  logic [MAX_K-1:0] lt;

  // strict compare keeps the lower row on a tie
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      lt[i] = (32'(i) < 32'(voters)) && (new_dist < best_d_r[i]);
    end
  end

  for (genvar i = 0; i < MAX_K; i++) begin : g_slot
    logic lt_prev;
    if (i == 0) begin : g_head
      assign lt_prev = 1'b0;
    end else begin : g_tail
      assign lt_prev = lt[i-1];
    end
    always_comb begin
      best_d_nxt[i]   = best_d_r[i];
      best_row_nxt[i] = best_row_r[i];
      if (lt[i] && !lt_prev) begin
        best_d_nxt[i]   = new_dist;
        best_row_nxt[i] = row;
      end else if (lt[i]) begin
        if (i > 0) begin
          best_d_nxt[i]   = best_d_r[(i > 0) ? i-1 : 0];
          best_row_nxt[i] = best_row_r[(i > 0) ? i-1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < MAX_K; i++) begin
        best_d_r[i]   <= '1;
        best_row_r[i] <= '0;
      end
    end else if (upd) begin
      for (int i = 0; i < MAX_K; i++) begin
        best_d_r[i]   <= best_d_nxt[i];
        best_row_r[i] <= best_row_nxt[i];
      end
    end
  end

  assign rd_row = best_row_r[rd_idx];

endmodule

>>> dv/knn_vote_checker.sv
// ---------------------------------------------------------------------------
// knn_vote_checker
// Watches the input, result and register channels of the k-NN classifier,
// keeps its own copy of the training set and query, predicts the class and
// vote count of every query, and compares each result item in order.
// ---------------------------------------------------------------------------
module knn_vote_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [9:0]         in_row,
  input  logic [5:0]         in_column,
  input  logic signed [15:0] in_feature_value,
  input  logic [3:0]         in_class_label,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         out_predicted_class,
  input  logic [3:0]         out_winning_votes,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_votes
);
  timeunit 1ns;
  timeprecision 1ps;
  import knn_pkg::*;

  typedef struct packed {
    logic [3:0] cls;
    logic [3:0] votes;
  } vote_t;

  logic signed [15:0] feat_mem [MAX_TRAIN_DEF][MAX_DIMS_DEF];
  logic [3:0]         label_mem [MAX_TRAIN_DEF];
  logic signed [15:0] query_mem [MAX_DIMS_DEF];
  logic [10:0]        rows_reg;
  logic [6:0]         dims_reg;
  logic [3:0]         k_reg;
  vote_t              vote_q [$];

  function automatic int clamp(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Brute-force scan, then nearest-first vote with strict lead change.
  function automatic vote_t classify_query();
    longint unsigned best_d [MAX_K_DEF];
    int              best_r [MAX_K_DEF];
    int              tally [NUM_CLASSES_DEF];
    int              nrows, ndims, nk, voters, pos, lead_n, lead_c, c;
    longint unsigned row_d;
    longint          diff;
    vote_t           res;
    nrows = clamp(rows_reg, MAX_TRAIN_DEF);
    ndims = clamp(dims_reg, MAX_DIMS_DEF);
    nk = clamp(k_reg, MAX_K_DEF);
    voters = nk < nrows ? nk : nrows;
    foreach (best_d[i]) begin
      best_d[i] = '1;
      best_r[i] = 0;
    end
    for (int r = 0; r < nrows; r++) begin
      row_d = 0;
      for (int d = 0; d < ndims; d++) begin
        diff = longint'(feat_mem[r][d]) - longint'(query_mem[d]);
        row_d += longint'(diff * diff);
      end
      pos = voters;
      while (pos > 0 && row_d < best_d[pos-1]) pos--;
      if (pos < voters) begin
        for (int i = voters - 1; i > pos; i--) begin
          best_d[i] = best_d[i-1];
          best_r[i] = best_r[i-1];
        end
        best_d[pos] = row_d;
        best_r[pos] = r;
      end
    end
    foreach (tally[i]) tally[i] = 0;
    lead_n = 0;
    lead_c = 0;
    for (int i = 0; i < voters; i++) begin
      c = label_mem[best_r[i]];
      tally[c]++;
      if (tally[c] > lead_n) begin
        lead_n = tally[c];
        lead_c = c;
      end
    end
    res.cls = lead_c[3:0];
    res.votes = lead_n[3:0];
    return res;
  endfunction

  always @(posedge clk) begin
    vote_t want;
    if (!rst_n) begin
      rows_reg = TRAIN_ROWS_RST;
      dims_reg = DIMS_USED_RST;
      k_reg = NEIGHBOURS_RST;
      vote_q.delete();
      fail_count <= 0;
      pending_votes <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TRAIN_ROWS: rows_reg = cfg_data;
          CFG_DIMS_USED: dims_reg = cfg_data[6:0];
          CFG_NEIGHBOURS: k_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_action)
          ACT_FEATURE: feat_mem[in_row][in_column] = in_feature_value;
          ACT_LABEL: label_mem[in_row] = in_class_label;
          ACT_QUERY: begin
            query_mem[in_column] = in_feature_value;
            if (in_last) vote_q = {vote_q, classify_query()};
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (vote_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = vote_q.pop_front();
          if (out_predicted_class !== want.cls || out_winning_votes !== want.votes)
            fail_count <= fail_count + 1;
          if (out_predicted_class !== want.cls)
            $error("predicted_class expected %0d got %0d", want.cls, out_predicted_class);
          if (out_winning_votes !== want.votes)
            $error("winning_votes expected %0d got %0d", want.votes, out_winning_votes);
        end
      end
      pending_votes <= vote_q.size();
    end
  end
endmodule

>>> dv/tb_knn_majority_vote_classifier_unit.sv
// ---------------------------------------------------------------------------
// tb_knn_majority_vote_classifier_unit
// Loads training sets, runs directed and random queries under several
// register settings and idling patterns; the checker predicts every vote.
// ---------------------------------------------------------------------------
module tb_knn_majority_vote_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import knn_pkg::*;

  // Action code that the block ignores.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_action;
  logic [9:0]         in_row;
  logic [5:0]         in_column;
  logic signed [15:0] in_feature_value;
  logic [3:0]         in_class_label;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_predicted_class;
  logic [3:0]         out_winning_votes;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [10:0]        cfg_data;
  int                 fail_count;
  int                 pending_votes;
  int                 cycle_count;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  // Rows and dims written so far: reads of unwritten entries are never caused.
  int                 rows_loaded;
  int                 dims_loaded;
  int                 cur_rows;
  int                 cur_dims;

  knn_majority_vote_classifier_unit uut (.*);

  knn_vote_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 500000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall at random per the active phase.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one item; valid holds until accepted, with a random gap first.
  // Valid stays high after the accept; the next caller drives it.
  task automatic send_item(input int act, input int r, input int c,
                           input int v, input int lbl, input int lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_action <= 2'(act);
    in_row <= 10'(r);
    in_column <= 6'(c);
    in_feature_value <= 16'(v);
    in_class_label <= 4'(lbl);
    in_last <= 1'(lst);
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, then wait until every expected vote has been taken.
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_votes != 0) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_data <= 11'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random values skewed toward the extremes now and then.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_row(input int r, input int dims);
    for (int d = 0; d < dims; d++) send_item(ACT_FEATURE, r, d, pick_value(), 0, $urandom_range(1));
    send_item(ACT_LABEL, r, $urandom, $urandom, $urandom, $urandom_range(1));
  endtask

  // Query of `dims` elements; last rides on the final one.
  task automatic run_query(input int dims, input bit extremes);
    for (int d = 0; d < dims; d++)
      send_item(ACT_QUERY, $urandom, d, extremes ? 16'h8000 : pick_value(), $urandom,
                d == dims - 1);
  endtask

  // Program a setting; load enough rows and dims to cover it.
  task automatic set_phase(input int rows, input int dims, input int k);
    drain_all();
    write_reg(CFG_TRAIN_ROWS, rows);
    write_reg(CFG_DIMS_USED, dims);
    write_reg(CFG_NEIGHBOURS, k);
    cur_rows = rows;
    cur_dims = dims;
    if (dims > dims_loaded) begin
      for (int r = 0; r < rows_loaded; r++)
        for (int d = dims_loaded; d < dims; d++)
          send_item(ACT_FEATURE, r, d, pick_value(), 0, 0);
      dims_loaded = dims;
    end
    while (rows_loaded < rows) begin
      load_row(rows_loaded, dims_loaded);
      rows_loaded++;
    end
  endtask

  task automatic random_burst(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 60) run_query(cur_dims, 0);
      else if (sel < 75) send_item(ACT_FEATURE, $urandom_range(rows_loaded - 1),
                                   $urandom_range(dims_loaded - 1), pick_value(), $urandom, 0);
      else if (sel < 85) send_item(ACT_LABEL, $urandom_range(rows_loaded - 1), $urandom,
                                   $urandom, $urandom, $urandom_range(1));
      else if (sel < 90) send_item(ACT_QUERY, $urandom, $urandom_range(cur_dims - 1),
                                   pick_value(), $urandom, 0);
      else if (sel < 95) send_item(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
      // Writes above the used dims are kept but never scanned.
      else send_item(ACT_FEATURE, $urandom, $urandom_range(63, dims_loaded < 64 ? dims_loaded : 63),
                     pick_value(), $urandom, 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_FEATURE;
    in_row = '0;
    in_column = '0;
    in_feature_value = '0;
    in_class_label = '0;
    in_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TRAIN_ROWS;
    cfg_data = '0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rows_loaded = 0;
    dims_loaded = 4;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one row at the field extremes, reset k with a single row.
    send_item(ACT_FEATURE, 0, 0, 16'h7FFF, 0, 0);
    send_item(ACT_FEATURE, 0, 1, 16'h8000, 0, 0);
    send_item(ACT_FEATURE, 0, 2, 16'h0000, 0, 0);
    send_item(ACT_FEATURE, 0, 3, 16'hFFFF, 0, 0);
    send_item(ACT_LABEL, 0, 0, 0, 4'd15, 0);
    rows_loaded = 1;
    set_phase(1, 4, 5);
    run_query(4, 1);
    send_item(ACT_UNUSED, 10'h3FF, 6'h3F, 16'hFFFF, 4'hF, 1);
    set_phase(9, 4, 8);
    run_query(4, 1);
    set_phase(9, 4, 1);
    run_query(4, 0);
    // Ties: duplicate rows must keep the lower one and its label.
    for (int d = 0; d < 4; d++) send_item(ACT_FEATURE, 1, d, 16'd0, 0, 0);
    for (int d = 0; d < 4; d++) send_item(ACT_FEATURE, 2, d, 16'd0, 0, 0);
    send_item(ACT_LABEL, 2, 0, 0, 4'd3, 0);
    run_query(4, 0);
    // Zero register values saturate up to one.
    drain_all();
    write_reg(CFG_TRAIN_ROWS, 0);
    write_reg(CFG_DIMS_USED, 0);
    write_reg(CFG_NEIGHBOURS, 0);
    cur_rows = 1;
    cur_dims = 1;
    run_query(1, 0);

    // Random phases, mostly small sizes to keep scans short.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = ph == 1 || ph == 3 ? (ph == 1 ? 60 : 29) : 0;
      recv_stall_pct = ph >= 2 ? (ph == 2 ? 60 : 29) : 0;
      set_phase($urandom_range(1, 16), $urandom_range(1, 6), $urandom_range(1, 8));
      random_burst(15);
      // Hold off until every result has been taken.
      drain_all();
      random_burst(15);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // Oversized dims and neighbours saturate; fill row 0 to full width.
    drain_all();
    write_reg(CFG_TRAIN_ROWS, 0);
    write_reg(CFG_DIMS_USED, 'h7F);
    write_reg(CFG_NEIGHBOURS, 'hF);
    for (int d = dims_loaded; d < 64; d++) send_item(ACT_FEATURE, 0, d, pick_value(), 0, 0);
    run_query(64, 0);

    drain_all();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
